@@ sv/bmof_pkg.sv @@
// Package for the bus map and operand fetch block: payload types, codes and decode helpers.
package bmof_pkg;

	localparam int WORK_RAM_BYTES_DEF = 2048;
	localparam int PROGRAM_BYTES_DEF  = 32768;

	localparam logic [3:0] FN_READ    = 4'd0;
	localparam logic [3:0] FN_WRITE   = 4'd1;
	localparam logic [3:0] FN_OPREAD  = 4'd2;
	localparam logic [3:0] FN_OPWRITE = 4'd3;
	localparam logic [3:0] FN_PUSH    = 4'd4;
	localparam logic [3:0] FN_PUSH16  = 4'd5;
	localparam logic [3:0] FN_POP     = 4'd6;
	localparam logic [3:0] FN_POP16   = 4'd7;
	localparam logic [3:0] FN_LOAD    = 4'd8;

	localparam logic [3:0] MD_IMM  = 4'd0;
	localparam logic [3:0] MD_ZP   = 4'd1;
	localparam logic [3:0] MD_ZPX  = 4'd2;
	localparam logic [3:0] MD_ZPY  = 4'd3;
	localparam logic [3:0] MD_ABS  = 4'd4;
	localparam logic [3:0] MD_ABSX = 4'd5;
	localparam logic [3:0] MD_ABSY = 4'd6;
	localparam logic [3:0] MD_INDX = 4'd7;
	localparam logic [3:0] MD_INDY = 4'd8;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ILL_READ  = 2'd1;
	localparam logic [1:0] ST_ILL_WRITE = 2'd2;
	localparam logic [1:0] ST_BAD_MODE  = 2'd3;

	localparam logic [3:0]  PPU_REG_DMA = 4'd8;
	localparam logic [15:0] ADDR_PPU    = 16'h2000;
	localparam logic [15:0] ADDR_IO     = 16'h4000;
	localparam logic [15:0] ADDR_DMA    = 16'h4014;
	localparam logic [15:0] ADDR_ILL    = 16'h4020;
	localparam logic [15:0] ADDR_OPEN   = 16'h6000;
	localparam logic [15:0] ADDR_PROG   = 16'h8000;
	localparam logic [2:0]  STACK_PAGE  = 3'b001;

	typedef struct packed {
		logic [3:0]  func;
		logic [15:0] address;
		logic [15:0] data;
		logic [3:0]  mode;
		logic [15:0] prog_counter;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  stack_ptr;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [7:0]  stack_ptr_out;
		logic        ppu_valid;
		logic        ppu_is_write;
		logic [3:0]  ppu_reg;
		logic [7:0]  ppu_wdata;
		logic        write_flag;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		RG_RAM, RG_PPU, RG_AUDIO, RG_ILLEGAL, RG_OPEN, RG_PROG
	} region_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_OP_LO, S_OP_HI, S_PTR_LO, S_PTR_HI,
		S_ACCESS, S_RDATA, S_STACK2, S_POP_LO, S_POP_HI, S_DONE
	} state_t;

	function automatic region_t region_of(input logic [15:0] a);
		region_t r;
		if (a < ADDR_PPU) r = RG_RAM;
		else if (a < ADDR_IO || a == ADDR_DMA) r = RG_PPU;
		else if (a < ADDR_ILL) r = RG_AUDIO;
		else if (a < ADDR_OPEN) r = RG_ILLEGAL;
		else if (a < ADDR_PROG) r = RG_OPEN;
		else r = RG_PROG;
		return r;
	endfunction

	function automatic logic [3:0] ppu_reg_of(input logic [15:0] a);
		logic [3:0] r;
		if (a == ADDR_DMA) r = PPU_REG_DMA;
		else r = {1'b0, a[2:0]};
		return r;
	endfunction

endpackage

@@ sv/cpu_bus_map_and_operand_fetch_top.sv @@
// Top level: bus map, operand address sequencer, work RAM and program store.
//
// Usage: drive req and pulse start while busy is low; that edge is the transfer
// of one request. busy stays high until the result has been shown. The result
// appears on rsp for exactly one cycle with done high; the receiver cannot
// stall, so it must take the transfer in that cycle.
// Steps after the accepting edge: decode; for operand reads, the operand low
// byte, then for absolute modes the high byte, or for indirect modes the
// pointer low and high bytes; then the access, plus a read-data step for reads
// from RAM or program store; push16 writes and pop16 reads a second stack byte;
// then done. Push, load and unknown functions or modes go from decode to done.
// One request is served at a time; a new request is taken only back in idle,
// after done. This is set by the single port of each memory: operand,
// pointer and data bytes are dependent reads, each with a registered read,
// all steered through one sequencer.
// After reset the block clears both memories, one entry per cycle, with busy
// high; no request is taken until the sweep ends. PPU accesses are only
// flagged on rsp; PPU read data is supplied elsewhere.
module cpu_bus_map_and_operand_fetch_top #(
	parameter int WORK_RAM_BYTES = bmof_pkg::WORK_RAM_BYTES_DEF,
	parameter int PROGRAM_BYTES  = bmof_pkg::PROGRAM_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bmof_pkg::req_t req,
	output logic           done,
	output bmof_pkg::rsp_t rsp
);
	import bmof_pkg::*;

	localparam int RW = $clog2(WORK_RAM_BYTES);
	localparam int PW = $clog2(PROGRAM_BYTES);

	state_t state_q, state_d;
	req_t req_q;
	rsp_t rsp_q;
	logic [15:0] ea_q;
	logic [7:0] lo_q, ptr_q, sp_q;
	logic io_hit_q;
	region_t src_q;
	logic [PW-1:0] clr_q;

	logic [7:0] work_ram [WORK_RAM_BYTES];
	logic [7:0] program_store [PROGRAM_BYTES];
	logic [7:0] ram_rd_q, prog_rd_q;

	// Datapath controls from the output decoder
	logic fetch_en;
	logic [15:0] fetch_addr;
	logic ram_we, prog_we;
	logic [RW-1:0] ram_addr;
	logic [PW-1:0] prog_addr;
	logic [7:0] ram_wd, prog_wd;

	logic [7:0] fb;
	logic [7:0] sp_inc, sp_dec;
	logic is_write;
	region_t ea_rg;

	assign sp_inc = sp_q + 8'd1;
	assign sp_dec = sp_q - 8'd1;
	assign is_write = (req_q.func == FN_WRITE) || (req_q.func == FN_OPWRITE);
	assign ea_rg = region_of(ea_q);

	// Byte returned by the last fetch; open bus and illegal ranges read zero
	always_comb begin
		case (src_q)
			RG_RAM:  fb = ram_rd_q;
			RG_PROG: fb = prog_rd_q;
			default: fb = 8'h00;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (&clr_q) state_d = S_IDLE;
			S_IDLE: if (start) state_d = S_DECODE;
			S_DECODE: begin
				case (req_q.func)
					FN_READ, FN_WRITE: state_d = S_ACCESS;
					FN_OPREAD, FN_OPWRITE: begin
						if (req_q.mode == MD_IMM) state_d = S_ACCESS;
						else if (req_q.mode <= MD_INDY) state_d = S_OP_LO;
						else state_d = S_DONE;
					end
					FN_PUSH16: state_d = S_STACK2;
					FN_POP, FN_POP16: state_d = S_POP_LO;
					default: state_d = S_DONE;
				endcase
			end
			S_OP_LO: begin
				if (req_q.mode == MD_ZP || req_q.mode == MD_ZPX || req_q.mode == MD_ZPY)
					state_d = S_ACCESS;
				else if (req_q.mode == MD_INDX || req_q.mode == MD_INDY)
					state_d = S_PTR_LO;
				else
					state_d = S_OP_HI;
			end
			S_OP_HI: state_d = S_ACCESS;
			S_PTR_LO: state_d = S_PTR_HI;
			S_PTR_HI: state_d = S_ACCESS;
			S_ACCESS: begin
				if (!io_hit_q && !is_write && (ea_rg == RG_RAM || ea_rg == RG_PROG))
					state_d = S_RDATA;
				else
					state_d = S_DONE;
			end
			S_RDATA: state_d = S_DONE;
			S_STACK2: state_d = S_DONE;
			S_POP_LO: state_d = (req_q.func == FN_POP16) ? S_POP_HI : S_DONE;
			S_POP_HI: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory and handshake controls
	always_comb begin
		fetch_en = 1'b0;
		fetch_addr = ea_q;
		ram_we = 1'b0;
		prog_we = 1'b0;
		ram_wd = req_q.data[7:0];
		prog_wd = req_q.data[7:0];
		ram_addr = '0;
		prog_addr = '0;
		done = 1'b0;
		busy = 1'b1;
		case (state_q)
			S_CLEAR: begin
				ram_we = (clr_q[PW-1:RW] == '0);
				prog_we = 1'b1;
				ram_wd = 8'h00;
				prog_wd = 8'h00;
				ram_addr = clr_q[RW-1:0];
				prog_addr = clr_q;
			end
			S_IDLE: busy = 1'b0;
			S_DECODE: begin
				case (req_q.func)
					FN_OPREAD, FN_OPWRITE: begin
						fetch_addr = req_q.prog_counter + 16'd1;
						fetch_en = (req_q.mode != MD_IMM) && (req_q.mode <= MD_INDY);
					end
					FN_PUSH: begin
						ram_we = 1'b1;
						ram_addr = RW'({STACK_PAGE, sp_q});
					end
					FN_PUSH16: begin
						ram_we = 1'b1;
						ram_wd = req_q.data[15:8];
						ram_addr = RW'({STACK_PAGE, sp_q});
					end
					FN_POP, FN_POP16: ram_addr = RW'({STACK_PAGE, sp_inc});
					FN_LOAD: begin
						prog_we = req_q.address[15];
						prog_addr = req_q.address[PW-1:0];
					end
					default: ;
				endcase
			end
			S_OP_LO: begin
				if (req_q.mode == MD_INDX) begin
					fetch_addr = {8'h00, 8'(fb + req_q.index_x)};
					fetch_en = 1'b1;
				end else if (req_q.mode == MD_INDY) begin
					fetch_addr = {8'h00, fb};
					fetch_en = 1'b1;
				end else if (req_q.mode >= MD_ABS) begin
					fetch_addr = req_q.prog_counter + 16'd2;
					fetch_en = 1'b1;
				end
			end
			S_PTR_LO: begin
				// pointer high byte wraps inside page zero
				fetch_addr = {8'h00, 8'(ptr_q + 8'd1)};
				fetch_en = 1'b1;
			end
			S_ACCESS: begin
				if (!io_hit_q) begin
					if (is_write) begin
						ram_we = (ea_rg == RG_RAM);
					end else begin
						fetch_en = (ea_rg == RG_RAM) || (ea_rg == RG_PROG);
					end
				end
			end
			S_STACK2: begin
				ram_we = 1'b1;
				ram_addr = RW'({STACK_PAGE, sp_q});
			end
			S_POP_LO: ram_addr = RW'({STACK_PAGE, sp_inc});
			S_DONE: done = 1'b1;
			default: ;
		endcase
		if (fetch_en || (state_q == S_ACCESS && is_write)) begin
			ram_addr = fetch_addr[RW-1:0];
			prog_addr = fetch_addr[PW-1:0];
		end
	end

	// Work RAM, single port, registered read
	always_ff @(posedge clk) begin
		if (ram_we) work_ram[ram_addr] <= ram_wd;
		ram_rd_q <= work_ram[ram_addr];
	end

	// Program store, single port, registered read
	always_ff @(posedge clk) begin
		if (prog_we) program_store[prog_addr] <= prog_wd;
		prog_rd_q <= program_store[prog_addr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// Request, address and result registers
	always_ff @(posedge clk) begin
		if (fetch_en) begin
			src_q <= region_of(fetch_addr);
			if (state_q != S_ACCESS) begin
				if (region_of(fetch_addr) == RG_PPU) io_hit_q <= 1'b1;
				if (region_of(fetch_addr) == RG_AUDIO || region_of(fetch_addr) == RG_ILLEGAL)
					rsp_q.status <= ST_ILL_READ;
			end
		end
		case (state_q)
			S_IDLE: begin
				req_q <= req;
				sp_q <= req.stack_ptr;
				io_hit_q <= 1'b0;
				rsp_q <= '0;
			end
			S_DECODE: begin
				case (req_q.func)
					FN_READ, FN_WRITE: ea_q <= req_q.address;
					FN_OPREAD, FN_OPWRITE: begin
						ea_q <= req_q.prog_counter + 16'd1;
						if (req_q.mode > MD_INDY) rsp_q.status <= ST_BAD_MODE;
					end
					FN_PUSH, FN_PUSH16: sp_q <= sp_dec;
					FN_POP, FN_POP16: sp_q <= sp_inc;
					default: ;
				endcase
			end
			S_OP_LO: begin
				lo_q <= fb;
				case (req_q.mode)
					MD_ZP:   ea_q <= {8'h00, fb};
					MD_ZPX:  ea_q <= {8'h00, 8'(fb + req_q.index_x)};
					MD_ZPY:  ea_q <= {8'h00, 8'(fb + req_q.index_y)};
					MD_INDX: ptr_q <= 8'(fb + req_q.index_x);
					default: ptr_q <= fb;
				endcase
			end
			S_OP_HI: begin
				if (req_q.mode == MD_ABSX) ea_q <= {fb, lo_q} + {8'h00, req_q.index_x};
				else if (req_q.mode == MD_ABSY) ea_q <= {fb, lo_q} + {8'h00, req_q.index_y};
				else ea_q <= {fb, lo_q};
			end
			S_PTR_LO: lo_q <= fb;
			S_PTR_HI: begin
				if (req_q.mode == MD_INDY) ea_q <= {fb, lo_q} + {8'h00, req_q.index_y};
				else ea_q <= {fb, lo_q};
			end
			S_ACCESS: begin
				if (io_hit_q) begin
					rsp_q.status <= ST_ILL_READ;
				end else if (is_write) begin
					case (ea_rg)
						RG_PPU: begin
							rsp_q.ppu_valid <= 1'b1;
							rsp_q.ppu_is_write <= 1'b1;
							rsp_q.ppu_reg <= ppu_reg_of(ea_q);
							rsp_q.ppu_wdata <= req_q.data[7:0];
							rsp_q.write_flag <= (ppu_reg_of(ea_q) == PPU_REG_DMA);
						end
						RG_AUDIO: rsp_q.write_flag <= 1'b1;
						RG_ILLEGAL: begin
							rsp_q.write_flag <= 1'b1;
							rsp_q.status <= ST_ILL_WRITE;
						end
						default: ;
					endcase
				end else begin
					case (ea_rg)
						RG_PPU: begin
							rsp_q.ppu_valid <= 1'b1;
							rsp_q.ppu_reg <= ppu_reg_of(ea_q);
						end
						RG_AUDIO, RG_ILLEGAL: rsp_q.status <= ST_ILL_READ;
						default: ;
					endcase
				end
			end
			S_RDATA: rsp_q.read_data <= {8'h00, fb};
			S_STACK2: sp_q <= sp_dec;
			S_POP_LO: begin
				lo_q <= ram_rd_q;
				rsp_q.read_data <= {8'h00, ram_rd_q};
				if (req_q.func == FN_POP16) sp_q <= sp_inc;
			end
			S_POP_HI: rsp_q.read_data <= {ram_rd_q, lo_q};
			default: ;
		endcase
	end

	always_comb begin
		rsp = rsp_q;
		rsp.stack_ptr_out = sp_q;
	end

	// Hold off requests, pulse done for one cycle only, and keep PPU fields clear without a PPU access
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held over two cycles");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer taken without busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result shown while idle");
	a_ppu_reg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.ppu_valid) |-> (rsp.ppu_reg == 4'd0 && rsp.ppu_wdata == 8'd0))
		else $error("ppu fields set without ppu access");

endmodule
